[design/lcmc_pkg.sv]
package lcmc_pkg;

    // Fixed cache geometry
    localparam int SET_COUNT  = 64;
    localparam int SET_BITS   = 6;
    localparam int LINE_SHIFT = 6;
    // Seen bitmap is stored as 64-bit words, indexed by the line bits above the set
    localparam int SEEN_WORD_BITS = 64;
    localparam int SEEN_SHIFT     = LINE_SHIFT + SET_BITS;

    typedef enum logic [1:0] {
        OUTCOME_HIT      = 2'd0,
        OUTCOME_CONFLICT = 2'd1,
        OUTCOME_COLD     = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } state_t;

    // Read and write strobes for one memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

[design/lcmc_set_store.sv]
module lcmc_set_store #(
    parameter int TAG_W    = 8,
    parameter int WAYS     = 8,
    parameter int WAY_BITS = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcmc_pkg::mem_cmd_t        cmd,
    input  logic [5:0]                rd_set,
    input  logic [5:0]                wr_set,
    input  logic [WAYS*TAG_W-1:0]     wr_tags,
    input  logic [WAYS-1:0]           wr_valid,
    input  logic [WAYS*WAY_BITS-1:0]  wr_rec,
    output logic [WAYS*TAG_W-1:0]     rd_tags,
    output logic [WAYS-1:0]           rd_valid,
    output logic [WAYS*WAY_BITS-1:0]  rd_rec
);
    import lcmc_pkg::*;

    localparam int REC_W = WAYS * WAY_BITS;
    localparam int ROW_W = WAYS * TAG_W + WAYS + REC_W;

    logic [ROW_W-1:0]     mem [SET_COUNT];
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 rd_ok_reg;
    logic [SET_COUNT-1:0] row_ok_reg;
    logic [REC_W-1:0]     rec_init;

    // Row storage, one row per set
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_set] <= {wr_tags, wr_valid, wr_rec};
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[rd_set];
        end
    end

    // Per-row written flags; an unwritten row reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_ok_reg[wr_set] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_ok_reg <= row_ok_reg[rd_set];
            end
        end
    end

    // Reset recency: way i in position i
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            rec_init[i*WAY_BITS +: WAY_BITS] = WAY_BITS'(i);
        end
    end

    assign rd_tags  = rd_row_reg[ROW_W-1 -: WAYS*TAG_W];
    assign rd_valid = rd_ok_reg ? rd_row_reg[REC_W +: WAYS] : '0;
    assign rd_rec   = rd_ok_reg ? rd_row_reg[REC_W-1:0] : rec_init;

endmodule

[design/lcmc_seen_store.sv]
module lcmc_seen_store #(
    parameter int AW = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcmc_pkg::mem_cmd_t                cmd,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [lcmc_pkg::SEEN_WORD_BITS-1:0] wr_data,
    output logic [lcmc_pkg::SEEN_WORD_BITS-1:0] rd_data,
    output logic                              busy
);
    import lcmc_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic [SEEN_WORD_BITS-1:0] mem [DEPTH];
    logic [SEEN_WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [AW-1:0]             clr_addr_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      mem_we;
    logic [AW-1:0]             mem_wa;
    logic [SEEN_WORD_BITS-1:0] mem_wd;

    // Clearing pass after reset, one word per cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Write port shared between the clearing pass and updates
    always_comb
    begin
        mem_we = busy_reg | cmd.wr_en;
        mem_wa = busy_reg ? clr_addr_reg : wr_addr;
        mem_wd = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[design/lcmc_update.sv]
module lcmc_update #(
    parameter int TAG_W    = 8,
    parameter int WAYS     = 8,
    parameter int WAY_BITS = 3
) (
    input  logic [TAG_W-1:0]                    tag,
    input  logic [5:0]                          bit_idx,
    input  logic [WAYS*TAG_W-1:0]               tags,
    input  logic [WAYS-1:0]                     valid,
    input  logic [WAYS*WAY_BITS-1:0]            rec,
    input  logic [lcmc_pkg::SEEN_WORD_BITS-1:0] seen_word,
    input  logic [31:0]                         count,
    output logic [WAYS*TAG_W-1:0]               new_tags,
    output logic [WAYS-1:0]                     new_valid,
    output logic [WAYS*WAY_BITS-1:0]            new_rec,
    output logic [lcmc_pkg::SEEN_WORD_BITS-1:0] new_seen_word,
    output logic [31:0]                         new_count,
    output lcmc_pkg::outcome_t                  outcome,
    output logic [WAY_BITS-1:0]                 way
);
    import lcmc_pkg::*;

    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                free_found;
    logic [WAY_BITS-1:0] free_way;
    logic                pos_found;
    logic [WAY_BITS-1:0] pos;

    // Tag match and free-way search, lowest way wins
    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && valid[w] && tags[w*TAG_W +: TAG_W] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!free_found && !valid[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
        end
    end

    // Way selection: hit way, else free way, else least recent
    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (free_found)
        begin
            way = free_way;
        end
        else
        begin
            way = rec[(WAYS-1)*WAY_BITS +: WAY_BITS];
        end
    end

    // Fill on miss, classify through the seen bitmap
    always_comb
    begin
        new_tags      = tags;
        new_valid     = valid;
        new_seen_word = seen_word;
        new_count     = count;
        outcome       = OUTCOME_HIT;
        if (!hit)
        begin
            new_tags[way*TAG_W +: TAG_W] = tag;
            new_valid[way]               = 1'b1;
            if (seen_word[bit_idx])
            begin
                outcome = OUTCOME_CONFLICT;
                if (count != '1)
                begin
                    new_count = count + 32'd1;
                end
            end
            else
            begin
                outcome                = OUTCOME_COLD;
                new_seen_word[bit_idx] = 1'b1;
            end
        end
    end

    // Move the way to the front, shifting the entries ahead of it back by one
    always_comb
    begin
        pos_found = 1'b0;
        pos       = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!pos_found && rec[i*WAY_BITS +: WAY_BITS] == way)
            begin
                pos_found = 1'b1;
                pos       = WAY_BITS'(i);
            end
        end
        new_rec = rec;
        new_rec[WAY_BITS-1:0] = way;
        for (int i = 1; i < WAYS; i++)
        begin
            if (WAY_BITS'(i) <= pos)
            begin
                new_rec[i*WAY_BITS +: WAY_BITS] = rec[(i-1)*WAY_BITS +: WAY_BITS];
            end
        end
    end

endmodule

[design/lru_cache_miss_classifier_unit.sv]
// Set-associative LRU cache model that classifies each access.
//
// Input channel: in_valid / in_ready carry one byte address per word. The
// set is address bits 11..6, the tag is the bits above 11.
// Output channel: out_valid / out_ready carry outcome (hit, conflict miss,
// cold miss), way_used and the saturating conflict_total.
//
// For each word, the accept edge reads the set row and the seen bitmap word
// from their memories; in ST_ACCESS, once the output register is free, the
// finish edge writes both back and loads the output register. The next word
// is accepted only after that write-back, in ST_IDLE.
//
// After reset the seen bitmap is cleared one 64-bit word per cycle, over all
// 2**(ADDR_BITS-12) words (256 at the default); in_ready stays low until it
// is done. Set rows reset through per-row written flags.
//
// If the receiver stalls, the finished result waits in the output register
// and the next word is accepted; its update holds until the register frees.
module lru_cache_miss_classifier_unit #(
    parameter int ADDR_BITS = 20,
    parameter int WAYS      = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           outcome,
    output logic [2:0]           way_used,
    output logic [31:0]          conflict_total
);
    import lcmc_pkg::*;

    localparam int TAG_W    = ADDR_BITS - SEEN_SHIFT;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

    state_t                    state_reg;
    state_t                    state_next;
    logic [ADDR_BITS-1:0]      addr_reg;
    logic [31:0]               conflict_reg;
    logic                      out_valid_reg;
    outcome_t                  outcome_reg;
    logic [2:0]                way_used_reg;
    logic [31:0]               total_reg;

    logic                      accept;
    logic                      finish;
    logic                      seen_busy;
    mem_cmd_t                  mem_cmd;

    logic [TAG_W-1:0]          tag;
    logic [5:0]                set_idx;
    logic [WAYS*TAG_W-1:0]     rd_tags;
    logic [WAYS-1:0]           rd_valid;
    logic [WAYS*WAY_BITS-1:0]  rd_rec;
    logic [SEEN_WORD_BITS-1:0] rd_seen;
    logic [WAYS*TAG_W-1:0]     new_tags;
    logic [WAYS-1:0]           new_valid;
    logic [WAYS*WAY_BITS-1:0]  new_rec;
    logic [SEEN_WORD_BITS-1:0] new_seen;
    logic [31:0]               new_count;
    outcome_t                  upd_outcome;
    logic [WAY_BITS-1:0]       upd_way;

    assign tag     = addr_reg[ADDR_BITS-1:SEEN_SHIFT];
    assign set_idx = addr_reg[SEEN_SHIFT-1:LINE_SHIFT];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!seen_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  ;
            ST_IDLE:   in_ready = 1'b1;
            ST_ACCESS: finish = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    assign accept        = in_valid && in_ready;
    assign mem_cmd.rd_en = accept;
    assign mem_cmd.wr_en = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            conflict_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                conflict_reg  <= new_count;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input word and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= address;
        end
        if (finish)
        begin
            outcome_reg  <= upd_outcome;
            way_used_reg <= 3'(upd_way);
            total_reg    <= new_count;
        end
    end

    lcmc_set_store #(
        .TAG_W    (TAG_W),
        .WAYS     (WAYS),
        .WAY_BITS (WAY_BITS)
    ) u_set_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mem_cmd),
        .rd_set   (address[SEEN_SHIFT-1:LINE_SHIFT]),
        .wr_set   (set_idx),
        .wr_tags  (new_tags),
        .wr_valid (new_valid),
        .wr_rec   (new_rec),
        .rd_tags  (rd_tags),
        .rd_valid (rd_valid),
        .rd_rec   (rd_rec)
    );

    lcmc_seen_store #(
        .AW (TAG_W)
    ) u_seen_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_addr (address[ADDR_BITS-1:SEEN_SHIFT]),
        .wr_addr (tag),
        .wr_data (new_seen),
        .rd_data (rd_seen),
        .busy    (seen_busy)
    );

    lcmc_update #(
        .TAG_W    (TAG_W),
        .WAYS     (WAYS),
        .WAY_BITS (WAY_BITS)
    ) u_update (
        .tag           (tag),
        .bit_idx       (set_idx),
        .tags          (rd_tags),
        .valid         (rd_valid),
        .rec           (rd_rec),
        .seen_word     (rd_seen),
        .count         (conflict_reg),
        .new_tags      (new_tags),
        .new_valid     (new_valid),
        .new_rec       (new_rec),
        .new_seen_word (new_seen),
        .new_count     (new_count),
        .outcome       (upd_outcome),
        .way           (upd_way)
    );

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign way_used       = way_used_reg;
    assign conflict_total = total_reg;

    // No word is taken while the seen bitmap is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        seen_busy |-> !in_ready)
        else $error("input accepted during bitmap clear");

    // A result only appears after an update cycle
    a_result_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_ACCESS))
        else $error("result without update cycle");

    // The conflict count never goes down
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> conflict_reg >= $past(conflict_reg))
        else $error("conflict count decreased");

endmodule
